// ----- src/gradient_palette_sample_assert.svh -----
// Assertion macros shared by the gradient ramp RTL.
`ifndef GRADIENT_PALETTE_SAMPLE_ASSERT_SVH
`define GRADIENT_PALETTE_SAMPLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gradient ramp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gradient ramp assertion failed");

`endif

// ----- src/gps_pkg.sv -----
`default_nettype none

package gps_pkg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Quotient bits of the blend weight division (weight is 0..65536).
    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic [16:0] pos;
        logic [23:0] colour;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SHIFT    = 6'b000100,
        S_SHIFT_WR = 6'b001000,
        S_DIV      = 6'b010000,
        S_BLEND    = 6'b100000
    } t_state;

    typedef enum logic [0:0] {
        CMD_SET    = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/gps_ram.sv -----
`default_nettype none

module gps_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/gps_div.sv -----
`default_nettype none

module gps_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [16:0]   i_num,
    input  wire logic [16:0]   i_den,
    output gps_pkg::t_div_stat o_stat,
    output logic      [16:0]   o_quot
);

    localparam int SW = $clog2(gps_pkg::DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_step;
    logic [17:0]   r_rem;
    logic [16:0]   r_den;
    logic [16:0]   r_quot;

    logic        trial;
    logic [17:0] rem_sub;

    // Numerator is num * 65536 with num <= den, so the remainder stays below 2 * den.
    assign trial   = r_rem >= {1'b0, r_den};
    assign rem_sub = trial ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(gps_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= {rem_sub[16:0], 1'b0};
            r_quot <= {r_quot[15:0], trial};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// ----- src/gradient_palette_sample.sv -----
// Gradient colour ramp with a sorted table of up to MAX_STOPS stops held in one
// RAM with a registered read. start is taken when busy is low; each item gives exactly
// one result, shown for one cycle with o_valid, and the receiver cannot stall it, so
// it must take every strobe. With n stops stored, the table is scanned with one RAM
// read per stop. When the table is empty, o_valid answers straight from idle with no
// scan. A set ends the scan for an update or a dropped stop; an insert then moves each
// stop above the new one up by one slot, with a read and a write per stop. A sample at
// or before the first stop or past the last one ends the scan; between stops the scan
// stops at the upper stop, the 17-step bit-serial weight divider forms the weight and
// the shared channel multiplier blends red, green and blue in turn.
// A sample with no stops gives black; a set on a full table at a new position is
// dropped with o_status high.
`default_nettype none

module gradient_palette_sample #(
    parameter int MAX_STOPS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [16:0] i_position,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output logic             o_valid,
    output logic      [7:0]  o_red_out,
    output logic      [7:0]  o_green_out,
    output logic      [7:0]  o_blue_out,
    output logic             o_status
);

`include "gradient_palette_sample_assert.svh"

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    gps_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_addr, n_addr;
    logic            r_rvalid, n_rvalid;
    logic [AW-1:0]   r_ridx, n_ridx;
    logic [CW-1:0]   r_ins, n_ins;
    logic [CW-1:0]   r_j, n_j;
    logic [1:0]      r_ch, n_ch;
    logic            r_ovalid, n_ovalid;

    gps_pkg::t_cmd   r_cmd, n_cmd;
    logic [16:0]     r_pos, n_pos;
    logic [23:0]     r_colour, n_colour;
    gps_pkg::t_entry r_prev, n_prev;
    gps_pkg::t_entry r_cur, n_cur;
    logic [16:0]     r_w, n_w;
    logic [7:0]      r_red, n_red;
    logic [7:0]      r_green, n_green;
    logic [7:0]      r_blue, n_blue;
    logic            r_status, n_status;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    gps_pkg::t_entry ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    gps_pkg::t_entry ram_rdata;

    logic               div_start;
    logic [16:0]        div_num;
    logic [16:0]        div_den;
    gps_pkg::t_div_stat div_stat;
    logic [16:0]        div_quot;

    logic [16:0]       in_pos_clamped;
    logic [16:0]       x_pos;
    logic              last_entry;
    gps_pkg::t_entry   new_entry;
    logic [7:0]        c0;
    logic [7:0]        c1;
    logic signed [8:0]  diff;
    logic signed [17:0] w_signed;
    logic signed [26:0] prod;
    logic [7:0]        ch_val;

    gps_ram #(
        .WIDTH($bits(gps_pkg::t_entry)),
        .DEPTH(MAX_STOPS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    gps_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_stat (div_stat),
        .o_quot (div_quot)
    );

    assign in_pos_clamped = (i_position > gps_pkg::ONE_Q16) ? gps_pkg::ONE_Q16 : i_position;
    assign x_pos          = {1'b0, r_pos[15:0]};
    assign last_entry     = (CW'(r_ridx) + CW'(1)) == r_count;
    assign new_entry      = '{pos: r_pos, colour: r_colour};

    // Shared channel blender: c0 + floor((c1 - c0) * w / 65536), exact mod 256.
    always_comb begin
        unique case (r_ch)
            2'd0:    begin c0 = r_prev.colour[23:16]; c1 = r_cur.colour[23:16]; end
            2'd1:    begin c0 = r_prev.colour[15:8];  c1 = r_cur.colour[15:8];  end
            default: begin c0 = r_prev.colour[7:0];   c1 = r_cur.colour[7:0];   end
        endcase
    end

    assign diff     = $signed({1'b0, c1}) - $signed({1'b0, c0});
    assign w_signed = $signed({1'b0, r_w});
    assign prod     = diff * w_signed;
    assign ch_val   = c0 + prod[23:16];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_addr   = r_addr;
        n_rvalid = 1'b0;
        n_ridx   = r_ridx;
        n_ins    = r_ins;
        n_j      = r_j;
        n_ch     = r_ch;
        n_ovalid = 1'b0;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_colour = r_colour;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_w      = r_w;
        n_red    = r_red;
        n_green  = r_green;
        n_blue   = r_blue;
        n_status = r_status;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = new_entry;
        ram_re    = 1'b0;
        ram_raddr = '0;

        div_start = 1'b0;
        div_num   = x_pos - r_prev.pos;
        div_den   = ram_rdata.pos - r_prev.pos;

        unique case (r_state)
            gps_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd    = gps_pkg::t_cmd'(i_command);
                    n_pos    = (i_command == gps_pkg::CMD_SAMPLE) ? i_position : in_pos_clamped;
                    n_colour = {i_red_in, i_green_in, i_blue_in};
                    n_addr   = '0;
                    n_ins    = '0;
                    if (r_count == '0) begin
                        // Empty table: answer at once.
                        n_ovalid = 1'b1;
                        n_red    = '0;
                        n_green  = '0;
                        n_blue   = '0;
                        n_status = 1'b0;
                        if (i_command == gps_pkg::CMD_SET) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = '{pos: in_pos_clamped,
                                          colour: {i_red_in, i_green_in, i_blue_in}};
                            n_count   = CW'(1);
                        end
                    end else begin
                        n_state = gps_pkg::S_SCAN;
                    end
                end
            end

            gps_pkg::S_SCAN: begin
                // Stream reads one per cycle; examine the entry read last cycle.
                if (r_addr < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr[AW-1:0];
                    n_addr    = r_addr + CW'(1);
                    n_rvalid  = 1'b1;
                    n_ridx    = r_addr[AW-1:0];
                end
                if (r_rvalid) begin
                    if (r_cmd == gps_pkg::CMD_SET) begin
                        if (ram_rdata.pos == r_pos) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_ridx;
                            n_ovalid  = 1'b1;
                            n_red     = '0;
                            n_green   = '0;
                            n_blue    = '0;
                            n_status  = 1'b0;
                            n_state   = gps_pkg::S_IDLE;
                        end else begin
                            if (ram_rdata.pos < r_pos) begin
                                n_ins = r_ins + CW'(1);
                            end
                            if (last_entry) begin
                                if (r_count == CW'(MAX_STOPS)) begin
                                    // Full: drop the new stop.
                                    n_ovalid = 1'b1;
                                    n_red    = '0;
                                    n_green  = '0;
                                    n_blue   = '0;
                                    n_status = 1'b1;
                                    n_state  = gps_pkg::S_IDLE;
                                end else begin
                                    n_j     = r_count;
                                    n_state = gps_pkg::S_SHIFT;
                                end
                            end
                        end
                    end else begin
                        if (x_pos <= ram_rdata.pos) begin
                            if (r_ridx == '0) begin
                                n_ovalid = 1'b1;
                                n_red    = ram_rdata.colour[23:16];
                                n_green  = ram_rdata.colour[15:8];
                                n_blue   = ram_rdata.colour[7:0];
                                n_status = 1'b0;
                                n_state  = gps_pkg::S_IDLE;
                            end else begin
                                n_cur     = ram_rdata;
                                div_start = 1'b1;
                                n_state   = gps_pkg::S_DIV;
                            end
                        end else if (last_entry) begin
                            n_ovalid = 1'b1;
                            n_red    = ram_rdata.colour[23:16];
                            n_green  = ram_rdata.colour[15:8];
                            n_blue   = ram_rdata.colour[7:0];
                            n_status = 1'b0;
                            n_state  = gps_pkg::S_IDLE;
                        end else begin
                            n_prev = ram_rdata;
                        end
                    end
                end
            end

            gps_pkg::S_SHIFT: begin
                if (r_j == r_ins) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ins[AW-1:0];
                    n_count   = r_count + CW'(1);
                    n_ovalid  = 1'b1;
                    n_red     = '0;
                    n_green   = '0;
                    n_blue    = '0;
                    n_status  = 1'b0;
                    n_state   = gps_pkg::S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_j - CW'(1));
                    n_state   = gps_pkg::S_SHIFT_WR;
                end
            end

            gps_pkg::S_SHIFT_WR: begin
                // Move the stop below up by one slot.
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = ram_rdata;
                n_j       = r_j - CW'(1);
                n_state   = gps_pkg::S_SHIFT;
            end

            gps_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_w     = div_quot;
                    n_ch    = 2'd0;
                    n_state = gps_pkg::S_BLEND;
                end
            end

            gps_pkg::S_BLEND: begin
                n_ch = r_ch + 2'd1;
                unique case (r_ch)
                    2'd0: n_red   = ch_val;
                    2'd1: n_green = ch_val;
                    default: begin
                        n_blue   = ch_val;
                        n_status = 1'b0;
                        n_ovalid = 1'b1;
                        n_state  = gps_pkg::S_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = gps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gps_pkg::S_IDLE;
            r_count  <= '0;
            r_addr   <= '0;
            r_rvalid <= 1'b0;
            r_ins    <= '0;
            r_j      <= '0;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_addr   <= n_addr;
            r_rvalid <= n_rvalid;
            r_ins    <= n_ins;
            r_j      <= n_j;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        r_colour <= n_colour;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_w      <= n_w;
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
        r_status <= n_status;
    end

    assign busy        = (r_state != gps_pkg::S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_status    = r_status;

    `GPS_ASSERT_NOW(a_full_drop, i_clk, i_rst_n, o_valid && o_status, r_count == CW'(MAX_STOPS))
    `GPS_ASSERT_NOW(a_div_free, i_clk, i_rst_n, div_start, !div_stat.busy)
    `GPS_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `GPS_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1, CW'(r_count - $past(r_count)) <= CW'(1))

endmodule

`default_nettype wire
